/* hdl/mhdv_pkg.sv */
// Shared types and constants for the max-heap delete-by-value block.
// Used by max_heap_delete_value and its port checker; depends on nothing.
package mhdv_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    // fixed payload widths of the stream ports
    localparam int KIND_W    = 2;
    localparam int IN_VAL_W  = 32;
    localparam int IN_IDX_W  = 8;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;   // value, index
    localparam int M_TDATA_W = 48;   // data, count, status, zero fill

    // output field positions inside m_tdata
    localparam int COUNT_LSB  = DATA_W;
    localparam int STATUS_LSB = DATA_W + COUNT_W;
    localparam int FILL_LSB   = DATA_W + COUNT_W + STATUS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_BUILD  = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

endpackage

/* hdl/max_heap_delete_value.sv */
// Steps: load writes at the end, read fetches one element, build sifts each node down from the last;
// delete scans for the value, then two build passes around a root-to-end swap (missing value: no build).
// Throughput: one item at a time, set by the sift sequencer on the one-read one-write memory.
// A new item is taken while the previous result still waits in the output register.
// Reset: count, mark and sequencer clear at once; heap memory contents are not cleared.
// Depends on mhdv_pkg.
module max_heap_delete_value
    import mhdv_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value, [39:32] index
    input  logic [KIND_W-1:0]    s_tuser,   // [1:0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] data, [40:32] count, [42:41] status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = IDX_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_DATA, S_SCAN, S_SCAN_CMP, S_BLD,
        S_SD_P, S_SD_L, S_SD_R, S_SD_DEC, S_SW1, S_SW2,
        S_SWP_A, S_SWP_B, S_SWP_C, S_SWP_D, S_RESP
    } state_t;

    logic signed [VALUE_BITS-1:0] heap_mem [CAPACITY];
    logic signed [VALUE_BITS-1:0] rdata_reg;
    logic [IDX_W-1:0]             rd_addr;
    logic                         we;
    logic [IDX_W-1:0]             wa;
    logic signed [VALUE_BITS-1:0] wd;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             mark_reg, mark_next;
    logic                         mark_vld_reg, mark_vld_next;
    logic                         del_reg, del_next;
    logic                         phase_reg, phase_next;
    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic [IDX_W-1:0]             scan_reg, scan_next;
    logic [CNT_W-1:0]             bld_reg, bld_next;
    logic [IDX_W-1:0]             pos_reg, pos_next;
    logic signed [VALUE_BITS-1:0] pv_reg, pv_next;
    logic signed [VALUE_BITS-1:0] lv_reg, lv_next;
    logic [IDX_W-1:0]             bpos_reg, bpos_next;
    logic signed [VALUE_BITS-1:0] bval_reg, bval_next;
    logic signed [VALUE_BITS-1:0] res_data_reg, res_data_next;
    status_t                      res_st_reg, res_st_next;
    logic                         m_vld_reg, m_vld_next;
    logic [DATA_W-1:0]            m_data_reg, m_data_next;
    logic [COUNT_W-1:0]           m_cnt_reg, m_cnt_next;
    status_t                      m_st_reg, m_st_next;

    logic                         accept;
    kind_t                        in_kind;
    logic [IN_VAL_W-1:0]          in_raw;
    logic [IN_IDX_W-1:0]          in_idx;
    logic [IN_VAL_W+63:0]         in_ext;
    logic signed [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS+DATA_W-1:0] d_ext;
    logic [CNT_W+COUNT_W-1:0]     c_ext;
    logic [PW-1:0]                lc, rc;
    logic                         l_ok, r_ok;
    logic [IDX_W-1:0]             lpos, rpos, last_pos;
    logic [IDX_W-1:0]             dec_pos;
    logic signed [VALUE_BITS-1:0] dec_val;

    // true when the element at a ranks strictly above the one at b
    function automatic logic ranks_above(
        input logic [IDX_W-1:0]             apos,
        input logic signed [VALUE_BITS-1:0] aval,
        input logic [IDX_W-1:0]             bpos,
        input logic signed [VALUE_BITS-1:0] bval,
        input logic                         mvld,
        input logic [IDX_W-1:0]             mpos
    );
        logic r;
        begin
            if (mvld && apos == mpos)
            begin
                r = (bpos != mpos);
            end
            else if (mvld && bpos == mpos)
            begin
                r = 1'b0;
            end
            else
            begin
                r = (aval > bval);
            end
            return r;
        end
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign in_kind  = kind_t'(s_tuser);
    assign in_raw   = s_tdata[IN_VAL_W-1:0];
    assign in_idx   = s_tdata[IN_VAL_W+IN_IDX_W-1:IN_VAL_W];
    assign in_ext   = {{64{in_raw[IN_VAL_W-1]}}, in_raw};
    assign in_val   = in_ext[VALUE_BITS-1:0];

    assign lc       = PW'({pos_reg, 1'b1});
    assign rc       = PW'({pos_reg, 1'b0}) + PW'(2);
    assign l_ok     = lc < PW'(count_reg);
    assign r_ok     = rc < PW'(count_reg);
    assign lpos     = lc[IDX_W-1:0];
    assign rpos     = rc[IDX_W-1:0];
    assign last_pos = IDX_W'(count_reg - CNT_W'(1));

    assign d_ext    = {{DATA_W{res_data_reg[VALUE_BITS-1]}}, res_data_reg};
    assign c_ext    = {{COUNT_W{1'b0}}, count_reg};

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-FILL_LSB){1'b0}}, m_st_reg, m_cnt_reg, m_data_reg};

    // pick the larger child, left first, strict compare
    always_comb
    begin
        dec_pos = pos_reg;
        dec_val = pv_reg;
        if (l_ok && ranks_above(lpos, lv_reg, dec_pos, dec_val, mark_vld_reg, mark_reg))
        begin
            dec_pos = lpos;
            dec_val = lv_reg;
        end
        if (r_ok && ranks_above(rpos, rdata_reg, dec_pos, dec_val, mark_vld_reg, mark_reg))
        begin
            dec_pos = rpos;
            dec_val = rdata_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        mark_next     = mark_reg;
        mark_vld_next = mark_vld_reg;
        del_next      = del_reg;
        phase_next    = phase_reg;
        val_next      = val_reg;
        scan_next     = scan_reg;
        bld_next      = bld_reg;
        pos_next      = pos_reg;
        pv_next       = pv_reg;
        lv_next       = lv_reg;
        bpos_next     = bpos_reg;
        bval_next     = bval_reg;
        res_data_next = res_data_reg;
        res_st_next   = res_st_reg;
        m_vld_next    = m_vld_reg;
        m_data_next   = m_data_reg;
        m_cnt_next    = m_cnt_reg;
        m_st_next     = m_st_reg;
        rd_addr       = pos_reg;
        we            = 1'b0;
        wa            = pos_reg;
        wd            = bval_reg;

        if (m_vld_reg && m_tready)
        begin
            m_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = IDX_W'(in_idx);
                if (accept)
                begin
                    val_next      = in_val;
                    res_data_next = '0;
                    res_st_next   = ST_OK;
                    del_next      = 1'b0;
                    phase_next    = 1'b0;
                    case (in_kind)
                        KIND_LOAD:
                        begin
                            if (32'(count_reg) >= 32'(CAPACITY))
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                wa         = IDX_W'(count_reg);
                                wd         = in_val;
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_RESP;
                        end
                        KIND_BUILD:
                        begin
                            bld_next   = count_reg;
                            state_next = S_BLD;
                        end
                        KIND_DELETE:
                        begin
                            scan_next = '0;
                            if (count_reg == '0)
                            begin
                                res_st_next = ST_NOT_FOUND;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                del_next   = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        KIND_READ:
                        begin
                            if (32'(in_idx) < 32'(count_reg))
                            begin
                                state_next = S_RD_DATA;
                            end
                            else
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RD_DATA:
            begin
                res_data_next = rdata_reg;
                state_next    = S_RESP;
            end
            S_SCAN:
            begin
                rd_addr    = scan_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (rdata_reg == val_reg)
                begin
                    mark_next     = scan_reg;
                    mark_vld_next = 1'b1;
                    bld_next      = count_reg;
                    state_next    = S_BLD;
                end
                else if (PW'(scan_reg) + PW'(1) == PW'(count_reg))
                begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    scan_next  = scan_reg + IDX_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_BLD:
            begin
                if (bld_reg == '0)
                begin
                    if (del_reg && !phase_reg)
                    begin
                        state_next = S_SWP_A;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    bld_next   = bld_reg - CNT_W'(1);
                    pos_next   = IDX_W'(bld_reg - CNT_W'(1));
                    state_next = S_SD_P;
                end
            end
            S_SD_P:
            begin
                rd_addr    = pos_reg;
                state_next = S_SD_L;
            end
            S_SD_L:
            begin
                rd_addr    = lpos;
                pv_next    = rdata_reg;
                state_next = S_SD_R;
            end
            S_SD_R:
            begin
                rd_addr    = rpos;
                lv_next    = rdata_reg;
                state_next = S_SD_DEC;
            end
            S_SD_DEC:
            begin
                if (dec_pos == pos_reg)
                begin
                    state_next = S_BLD;
                end
                else
                begin
                    bpos_next = dec_pos;
                    bval_next = dec_val;
                    // the mark follows its element through the exchange
                    if (mark_vld_reg && mark_reg == pos_reg)
                    begin
                        mark_next = dec_pos;
                    end
                    else if (mark_vld_reg && mark_reg == dec_pos)
                    begin
                        mark_next = pos_reg;
                    end
                    state_next = S_SW1;
                end
            end
            S_SW1:
            begin
                we         = 1'b1;
                wa         = pos_reg;
                wd         = bval_reg;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                we         = 1'b1;
                wa         = bpos_reg;
                wd         = pv_reg;
                pos_next   = bpos_reg;
                state_next = S_SD_P;
            end
            S_SWP_A:
            begin
                rd_addr    = '0;
                state_next = S_SWP_B;
            end
            S_SWP_B:
            begin
                rd_addr    = last_pos;
                pv_next    = rdata_reg;
                state_next = S_SWP_C;
            end
            S_SWP_C:
            begin
                we         = 1'b1;
                wa         = '0;
                wd         = rdata_reg;
                state_next = S_SWP_D;
            end
            S_SWP_D:
            begin
                // old root drops off the end; clear the mark and rebuild
                we            = 1'b1;
                wa            = last_pos;
                wd            = pv_reg;
                count_next    = count_reg - CNT_W'(1);
                bld_next      = count_reg - CNT_W'(1);
                mark_vld_next = 1'b0;
                mark_next     = '0;
                phase_next    = 1'b1;
                state_next    = S_BLD;
            end
            S_RESP:
            begin
                if (!m_vld_reg || m_tready)
                begin
                    m_vld_next  = 1'b1;
                    m_data_next = d_ext[DATA_W-1:0];
                    m_cnt_next  = c_ext[COUNT_W-1:0];
                    m_st_next   = res_st_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            heap_mem[wa] <= wd;
        end
        rdata_reg <= heap_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            mark_reg     <= '0;
            mark_vld_reg <= 1'b0;
            del_reg      <= 1'b0;
            phase_reg    <= 1'b0;
            val_reg      <= '0;
            scan_reg     <= '0;
            bld_reg      <= '0;
            pos_reg      <= '0;
            pv_reg       <= '0;
            lv_reg       <= '0;
            bpos_reg     <= '0;
            bval_reg     <= '0;
            res_data_reg <= '0;
            res_st_reg   <= ST_OK;
            m_vld_reg    <= 1'b0;
            m_data_reg   <= '0;
            m_cnt_reg    <= '0;
            m_st_reg     <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            mark_reg     <= mark_next;
            mark_vld_reg <= mark_vld_next;
            del_reg      <= del_next;
            phase_reg    <= phase_next;
            val_reg      <= val_next;
            scan_reg     <= scan_next;
            bld_reg      <= bld_next;
            pos_reg      <= pos_next;
            pv_reg       <= pv_next;
            lv_reg       <= lv_next;
            bpos_reg     <= bpos_next;
            bval_reg     <= bval_next;
            res_data_reg <= res_data_next;
            res_st_reg   <= res_st_next;
            m_vld_reg    <= m_vld_next;
            m_data_reg   <= m_data_next;
            m_cnt_reg    <= m_cnt_next;
            m_st_reg     <= m_st_next;
        end
    end

endmodule

/* hdl/mhdv_checker.sv */
// Port-level checker for max_heap_delete_value, attached by bind.
// Depends on mhdv_pkg.
module mhdv_checker
    import mhdv_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [KIND_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    assign st = m_tdata[STATUS_LSB+STATUS_W-1:STATUS_LSB];

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown(s_tuser))
        else $error("kind unknown on a valid input");

    // one item in flight: busy after each input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == ST_FULL |->
            m_tdata[COUNT_LSB+COUNT_W-1:COUNT_LSB] == COUNT_W'(CAPACITY))
        else $error("full reported below capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st != ST_OK |-> m_tdata[DATA_W-1:0] == '0)
        else $error("data not zero on a failed operation");

endmodule

bind max_heap_delete_value mhdv_checker #(.CAPACITY(CAPACITY)) u_mhdv_checker (.*);
